// ----- rtl/sdes_pkg.sv -----
package sdes_pkg;

	// configuration register indexes
	localparam logic [1:0] CFG_KEY   = 2'd0;
	localparam logic [1:0] CFG_SBOX0 = 2'd1;
	localparam logic [1:0] CFG_SBOX1 = 2'd2;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [9:0]  KEY_RESET   = 10'd0;
	localparam logic [31:0] SBOX0_RESET = 32'hB7D8_1BB1;
	localparam logic [31:0] SBOX1_RESET = 32'hC613_D2E4;

	localparam logic [3:0] TAB_P10 [10] = '{4'd2, 4'd4, 4'd1, 4'd6, 4'd3,
		4'd9, 4'd0, 4'd8, 4'd7, 4'd5};
	localparam logic [3:0] TAB_LS1 [10] = '{4'd1, 4'd2, 4'd3, 4'd4, 4'd0,
		4'd6, 4'd7, 4'd8, 4'd9, 4'd5};
	localparam logic [3:0] TAB_LS2 [10] = '{4'd2, 4'd3, 4'd4, 4'd0, 4'd1,
		4'd7, 4'd8, 4'd9, 4'd5, 4'd6};
	localparam logic [3:0] TAB_P8 [8] = '{4'd5, 4'd2, 4'd6, 4'd3, 4'd7, 4'd4, 4'd9, 4'd8};
	localparam logic [2:0] TAB_IP [8] = '{3'd1, 3'd5, 3'd2, 3'd0, 3'd3, 3'd7, 3'd4, 3'd6};
	localparam logic [2:0] TAB_EP [8] = '{3'd7, 3'd4, 3'd5, 3'd6, 3'd5, 3'd6, 3'd7, 3'd4};
	localparam logic [2:0] TAB_FP [8] = '{3'd3, 3'd0, 3'd2, 3'd4, 3'd6, 3'd1, 3'd7, 3'd5};

	typedef struct packed {
		logic [7:0]  k1;
		logic [7:0]  k2;
		logic [31:0] sbox0;
		logic [31:0] sbox1;
	} sdes_keys_t;

	function automatic logic [9:0] perm10(input logic [9:0] v, input logic [3:0] tab [10]);
		logic [9:0] r;
		for (int i = 0; i < 10; i++) r[i] = v[tab[i]];
		return r;
	endfunction

	function automatic logic [7:0] perm_p8(input logic [9:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[TAB_P8[i]];
		return r;
	endfunction

	function automatic logic [7:0] perm8(input logic [7:0] v, input logic [2:0] tab [8]);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[i] = v[tab[i]];
		return r;
	endfunction

	function automatic logic [7:0] reverse8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) r[7 - i] = v[i];
		return r;
	endfunction

endpackage

// ----- rtl/sdes_ifs.sv -----
interface sdes_in_if;
	logic       valid;
	logic       ready;
	logic       command;
	logic [7:0] data_byte;

	modport source (output valid, output command, output data_byte, input ready);
	modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface sdes_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;

	modport source (output valid, output result_byte, input ready);
	modport sink   (input valid, input result_byte, output ready);
endinterface

// ----- rtl/sdes_byte_cipher.sv -----
// sdes_byte_cipher: s-des on one byte per transfer
// path: an input byte is registered in stages s1, s2 and s3 before its output transfer
// throughput: one byte per cycle unless out_ch.ready stalls it; each of the three stages holds its byte on a stall
// reset: arst_n clears all stage valid bits, key to zero and both s-boxes to the
// standard tables; configuration writes act at once, also on bytes in stages 2 and 3
module sdes_byte_cipher
	import sdes_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	sdes_in_if.sink               in_ch,
	sdes_out_if.source            out_ch
);

	sdes_keys_t keys;

	// stage valid bits and payload
	logic       valid_s1;
	logic       valid_s2;
	logic       valid_s3;
	logic       cmd_s1;
	logic       cmd_s2;
	logic [7:0] ip_s1;
	logic [7:0] ext_s2;
	logic [7:0] result_s3;

	// load enables, computed from the output backward
	logic en_s1;
	logic en_s2;
	logic en_s3;

	logic [7:0] msg;
	logic [7:0] key_a;
	logic [7:0] key_b;
	logic [7:0] mix_a;
	logic [7:0] mix_b;
	logic [7:0] fp_out;

	sdes_keysched u_keysched (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.keys      (keys)
	);

	// a stage takes new data when it is empty or its content moves on
	assign en_s3 = !valid_s3 || out_ch.ready;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign in_ch.ready = en_s1;

	// stage 1: encrypt bit-reverses the plaintext first, then initial permutation
	assign msg = in_ch.command ? in_ch.data_byte : reverse8(in_ch.data_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_ch.valid) begin
			cmd_s1 <= in_ch.command;
			ip_s1  <= perm8(msg, TAB_IP);
		end
	end

	// stage 2: first round, k1 for encrypt and k2 for decrypt, then half swap
	assign key_a = cmd_s1 ? keys.k2 : keys.k1;

	sdes_feistel u_round_a (
		.data   (ip_s1),
		.subkey (key_a),
		.sbox0  (keys.sbox0),
		.sbox1  (keys.sbox1),
		.mixed  (mix_a)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			cmd_s2 <= cmd_s1;
			ext_s2 <= {mix_a[3:0], mix_a[7:4]};
		end
	end

	// stage 3: second round with the other subkey, no swap, final permutation
	assign key_b = cmd_s2 ? keys.k1 : keys.k2;

	sdes_feistel u_round_b (
		.data   (ext_s2),
		.subkey (key_b),
		.sbox0  (keys.sbox0),
		.sbox1  (keys.sbox1),
		.mixed  (mix_b)
	);

	assign fp_out = perm8(mix_b, TAB_FP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	// decrypt bit-reverses the recovered byte
	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			result_s3 <= cmd_s2 ? reverse8(fp_out) : fp_out;
		end
	end

	assign out_ch.valid       = valid_s3;
	assign out_ch.result_byte = result_s3;

endmodule

// ----- rtl/sdes_keysched.sv -----
module sdes_keysched
	import sdes_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output sdes_keys_t            keys
);

	logic [9:0]  key_q;
	logic [31:0] sbox0_q;
	logic [31:0] sbox1_q;
	logic [9:0]  p10;
	logic [9:0]  ls1;
	logic [9:0]  ls2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q   <= KEY_RESET;
			sbox0_q <= SBOX0_RESET;
			sbox1_q <= SBOX1_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_KEY:   key_q   <= cfg_data[9:0];
				CFG_SBOX0: sbox0_q <= cfg_data;
				CFG_SBOX1: sbox1_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// subkeys: P10, rotate halves by 1 for k1, by 2 more for k2, then P8
	always_comb begin
		p10 = perm10(key_q, TAB_P10);
		ls1 = perm10(p10, TAB_LS1);
		ls2 = perm10(ls1, TAB_LS2);
		keys.k1    = perm_p8(ls1);
		keys.k2    = perm_p8(ls2);
		keys.sbox0 = sbox0_q;
		keys.sbox1 = sbox1_q;
	end

endmodule

// ----- rtl/sdes_feistel.sv -----
module sdes_feistel
	import sdes_pkg::*;
(
	input  logic [7:0]  data,
	input  logic [7:0]  subkey,
	input  logic [31:0] sbox0,
	input  logic [31:0] sbox1,
	output logic [7:0]  mixed
);

	logic [7:0]  x;
	logic [3:0]  idx0;
	logic [3:0]  idx1;
	logic [31:0] sh0;
	logic [31:0] sh1;
	logic [1:0]  s0;
	logic [1:0]  s1;
	logic [3:0]  f;

	always_comb begin
		x    = perm8(data, TAB_EP) ^ subkey;
		// row from outer bits, column from inner bits
		idx0 = {x[3], x[0], x[2], x[1]};
		idx1 = {x[7], x[4], x[6], x[5]};
		sh0  = sbox0 >> {idx0, 1'b0};
		sh1  = sbox1 >> {idx1, 1'b0};
		s0   = sh0[1:0];
		s1   = sh1[1:0];
		f    = {s0[0], s1[0], s1[1], s0[1]};
		mixed = {data[7:4], f ^ data[3:0]};
	end

endmodule

// ----- rtl/sdes_chk.sv -----
module sdes_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] result_byte
);

	logic [1:0] cnt_q;
	logic       up;
	logic       dn;

	assign up = in_valid && in_ready;
	assign dn = out_valid && out_ready;

	// bytes inside the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			case ({up, dn})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_byte))
		else $error("result dropped or changed during stall");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cnt_q != 2'd0)
		else $error("result without a pending byte");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd3 && !out_ready |-> !in_ready)
		else $error("input taken with all stages full");

	a_rate: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd0 && out_ready |-> ##3 cnt_q != 2'd0 || $past(dn, 3) ||
			$past(dn, 2) || $past(dn, 1) || dn)
		else $error("pending byte not delivered");

endmodule

bind sdes_byte_cipher sdes_chk u_sdes_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_ch.valid),
	.in_ready    (in_ch.ready),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.result_byte (out_ch.result_byte)
);
